FILE: rtl/telp_pkg.sv
// ----------------------------------------------------------------------------
// telp_pkg
// Types, character codes and helper functions for the cell literal parser.
// ----------------------------------------------------------------------------
package telp_pkg;

    localparam int TDATA_W = 96;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_ZERO      = 8'h30;

    localparam logic [7:0] ESC_CHARCODE = 8'h43;  // C
    localparam logic [7:0] ESC_CHARSET  = 8'h63;  // c
    localparam logic [7:0] ESC_INTEN    = 8'h69;  // i
    localparam logic [7:0] ESC_POL      = 8'h70;  // p
    localparam logic [7:0] ESC_UL       = 8'h75;  // u
    localparam logic [7:0] ESC_FG_LOW   = 8'h5B;  // [
    localparam logic [7:0] ESC_FG_HIGH  = 8'h3C;  // <
    localparam logic [7:0] ESC_FG_GREY  = 8'h7B;  // {
    localparam logic [7:0] ESC_FG_TRUE  = 8'h28;  // (
    localparam logic [7:0] ESC_BG_LOW   = 8'h5D;  // ]
    localparam logic [7:0] ESC_BG_HIGH  = 8'h3E;  // >
    localparam logic [7:0] ESC_BG_GREY  = 8'h7D;  // }
    localparam logic [7:0] ESC_BG_TRUE  = 8'h29;  // )
    localparam logic [7:0] ESC_UNICODE  = 8'h55;  // U
    localparam logic [7:0] ESC_RESET    = 8'h78;  // x

    localparam logic [23:0] GLYPH_SPACE   = 24'h000020;
    localparam logic [7:0]  CHARSET_RESET = 8'h42;

    localparam logic [2:0] KIND_DEFAULT = 3'd0;
    localparam logic [2:0] KIND_LOW     = 3'd1;
    localparam logic [2:0] KIND_HIGH    = 3'd2;
    localparam logic [2:0] KIND_GREY    = 3'd3;
    localparam logic [2:0] KIND_TRUE    = 3'd4;

    localparam logic [1:0] INTEN_NORMAL = 2'd0;
    localparam logic [1:0] INTEN_BOLD   = 2'd1;
    localparam logic [1:0] INTEN_FAINT  = 2'd2;

    // colour sub-steps
    localparam logic [3:0] SUB_LOW    = 4'd0;
    localparam logic [3:0] SUB_HIGH_R = 4'd1;
    localparam logic [3:0] SUB_HIGH_G = 4'd2;
    localparam logic [3:0] SUB_HIGH_B = 4'd3;
    localparam logic [3:0] SUB_GREY_0 = 4'd4;
    localparam logic [3:0] SUB_GREY_1 = 4'd5;
    localparam logic [3:0] SUB_TRUE_0 = 4'd6;
    localparam logic [3:0] SUB_TRUE_1 = 4'd7;
    localparam logic [3:0] SUB_TRUE_2 = 4'd8;
    localparam logic [3:0] SUB_TRUE_3 = 4'd9;
    localparam logic [3:0] SUB_TRUE_4 = 4'd10;

    typedef struct packed {
        logic [7:0]  cs_code;
        logic        cs_ext;
        logic [1:0]  intensity;
        logic        polarity;
        logic        underline;
        logic [2:0]  fg_kind;
        logic [23:0] fg_value;
        logic [2:0]  bg_kind;
        logic [23:0] bg_value;
    } attr_t;

    typedef struct packed {
        logic [23:0] glyph_bytes;
        logic        glyph_is_utf8;
        attr_t       attr;
    } cell_t;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        begin
            hex_val = 4'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                t = c - 8'h30;
                hex_val = t[3:0];
            end else if (c >= 8'h61 && c <= 8'h66) begin
                t = c - 8'h57;
                hex_val = t[3:0];
            end else if (c >= 8'h41 && c <= 8'h46) begin
                t = c - 8'h37;
                hex_val = t[3:0];
            end
        end
    endfunction

    function automatic logic [23:0] utf8_encode(input logic [15:0] v);
        begin
            if (v <= 16'h007F) begin
                utf8_encode = {17'd0, v[6:0]};
            end else if (v <= 16'h07FF) begin
                utf8_encode = {8'd0, 2'b10, v[5:0], 3'b110, v[10:6]};
            end else begin
                utf8_encode = {2'b10, v[5:0], 2'b10, v[11:6], 4'b1110, v[15:12]};
            end
        end
    endfunction

endpackage

FILE: rtl/terminal_element_literal_parser_top.sv
// ----------------------------------------------------------------------------
// terminal_element_literal_parser_top
// Cell literal parser: characters in, attributed terminal cells out.
// ----------------------------------------------------------------------------
// The slave stream takes one character per request, s_tlast marking the final
// character of the literal. The master stream gives one cell per request when
// a glyph completes the cell or when the last character arrives; characters
// that only select or fill attributes give no cell.
// Each character is one state transition, so one request is taken per cycle
// while s_tready is high. A completed cell is registered in the main entry
// of a two-entry output register (main plus skid), or in the skid entry while
// a main cell waits, so the block keeps taking characters; s_tready drops only
// when both entries hold cells, and rises again once the receiver takes one.
// Reset (aresetn low, synchronous) empties the output, returns the parser
// to idle and sets default attributes with charset designator 'B'.
// Attributes and designator persist from cell to cell.
// ----------------------------------------------------------------------------
module terminal_element_literal_parser_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // ch
    input  logic                          s_tlast,   // last_char
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // glyph_bytes, charset_designator, charset_extended, intensity_out,
    // polarity_out, underline_out, fg_kind, fg_value, bg_kind, bg_value, zero pad
    output logic [telp_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser    // glyph_is_utf8
);
    import telp_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ESC, PH_CC0, PH_CC1, PH_CC2, PH_CSET, PH_CSET_EXT,
        PH_INTEN, PH_POL, PH_UL, PH_COLOUR, PH_U0, PH_U1, PH_U2, PH_U3
    } phase_t;

    localparam attr_t ATTR_RESET = '{
        cs_code: CHARSET_RESET, cs_ext: 1'b0, intensity: INTEN_NORMAL,
        polarity: 1'b0, underline: 1'b0, fg_kind: KIND_DEFAULT, fg_value: 24'd0,
        bg_kind: KIND_DEFAULT, bg_value: 24'd0};

    phase_t      phase_reg, phase_next;
    attr_t       attr_reg, attr_next;
    logic        which_reg, which_next;
    logic [3:0]  sub_reg, sub_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic [7:0]  grey_reg, grey_next;
    logic [15:0] point_reg, point_next;

    cell_t       out_reg, skid_reg, cell_next;
    logic        out_valid_reg, skid_valid_reg;

    logic [7:0]  dec;
    logic [3:0]  hex;
    logic [7:0]  code_mul, grey_mul;
    logic [15:0] point_shift;
    logic        done, emit, accept, pop;
    logic        col_set;
    logic [2:0]  col_kind;
    logic [23:0] col_value;

    assign dec         = s_tdata - CH_ZERO;
    assign hex         = hex_val(s_tdata);
    assign code_mul    = {code_reg[4:0], 3'b000} + {code_reg[6:0], 1'b0};
    assign grey_mul    = {grey_reg[4:0], 3'b000} + {grey_reg[6:0], 1'b0};
    assign point_shift = {point_reg[11:0], hex};

    always_comb begin
        phase_next  = phase_reg;
        attr_next   = attr_reg;
        which_next  = which_reg;
        sub_next    = sub_reg;
        code_next   = code_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        grey_next   = grey_reg;
        point_next  = point_reg;
        cell_next.glyph_bytes   = GLYPH_SPACE;
        cell_next.glyph_is_utf8 = 1'b0;
        done        = 1'b0;
        col_set     = 1'b0;
        col_kind    = KIND_DEFAULT;
        col_value   = 24'd0;
        case (phase_reg)
            PH_IDLE: begin
                if (s_tdata == CH_BACKSLASH) begin
                    phase_next = PH_ESC;
                end else begin
                    cell_next.glyph_bytes = {16'd0, s_tdata};
                    done = 1'b1;
                end
            end
            PH_ESC: begin
                phase_next = PH_IDLE;
                case (s_tdata)
                    ESC_CHARCODE: phase_next = PH_CC0;
                    ESC_CHARSET:  phase_next = PH_CSET;
                    ESC_INTEN:    phase_next = PH_INTEN;
                    ESC_POL:      phase_next = PH_POL;
                    ESC_UL:       phase_next = PH_UL;
                    ESC_FG_LOW: begin
                        phase_next = PH_COLOUR; which_next = 1'b0; sub_next = SUB_LOW;
                    end
                    ESC_FG_HIGH: begin
                        phase_next = PH_COLOUR; which_next = 1'b0; sub_next = SUB_HIGH_R;
                    end
                    ESC_FG_GREY: begin
                        phase_next = PH_COLOUR; which_next = 1'b0; sub_next = SUB_GREY_0;
                    end
                    ESC_FG_TRUE: begin
                        phase_next = PH_COLOUR; which_next = 1'b0; sub_next = SUB_TRUE_0;
                    end
                    ESC_BG_LOW: begin
                        phase_next = PH_COLOUR; which_next = 1'b1; sub_next = SUB_LOW;
                    end
                    ESC_BG_HIGH: begin
                        phase_next = PH_COLOUR; which_next = 1'b1; sub_next = SUB_HIGH_R;
                    end
                    ESC_BG_GREY: begin
                        phase_next = PH_COLOUR; which_next = 1'b1; sub_next = SUB_GREY_0;
                    end
                    ESC_BG_TRUE: begin
                        phase_next = PH_COLOUR; which_next = 1'b1; sub_next = SUB_TRUE_0;
                    end
                    ESC_UNICODE:  phase_next = PH_U0;
                    ESC_RESET: begin
                        attr_next.intensity = INTEN_NORMAL;
                        attr_next.polarity  = 1'b0;
                        attr_next.underline = 1'b0;
                        attr_next.fg_kind   = KIND_DEFAULT;
                        attr_next.fg_value  = 24'd0;
                        attr_next.bg_kind   = KIND_DEFAULT;
                        attr_next.bg_value  = 24'd0;
                    end
                    default: begin
                        cell_next.glyph_bytes = {16'd0, s_tdata};
                        done = 1'b1;
                    end
                endcase
            end
            PH_CC0: begin
                code_next  = dec;
                phase_next = PH_CC1;
            end
            PH_CC1: begin
                code_next  = code_mul + dec;
                phase_next = PH_CC2;
            end
            PH_CC2: begin
                code_next = code_mul + dec;
                cell_next.glyph_bytes = {16'd0, code_next};
                done = 1'b1;
            end
            PH_CSET: begin
                if (s_tdata == CH_PERCENT) begin
                    phase_next = PH_CSET_EXT;
                end else begin
                    attr_next.cs_code = s_tdata;
                    attr_next.cs_ext  = 1'b0;
                    phase_next = PH_IDLE;
                end
            end
            PH_CSET_EXT: begin
                attr_next.cs_code = s_tdata;
                attr_next.cs_ext  = 1'b1;
                phase_next = PH_IDLE;
            end
            PH_INTEN: begin
                attr_next.intensity = (s_tdata == CH_GT) ? INTEN_BOLD :
                                      (s_tdata == CH_LT) ? INTEN_FAINT : INTEN_NORMAL;
                phase_next = PH_IDLE;
            end
            PH_POL: begin
                attr_next.polarity = (s_tdata == CH_MINUS);
                phase_next = PH_IDLE;
            end
            PH_UL: begin
                attr_next.underline = (s_tdata == CH_PLUS);
                phase_next = PH_IDLE;
            end
            PH_COLOUR: begin
                sub_next = sub_reg + 4'd1;
                case (sub_reg)
                    SUB_LOW: begin
                        col_set = 1'b1; col_kind = KIND_LOW; col_value = {16'd0, dec};
                    end
                    SUB_HIGH_R: red_next = dec;
                    SUB_HIGH_G: green_next = dec;
                    SUB_HIGH_B: begin
                        col_set = 1'b1; col_kind = KIND_HIGH;
                        col_value = {red_reg, green_reg, dec};
                    end
                    SUB_GREY_0: grey_next = dec;
                    SUB_GREY_1: begin
                        col_set = 1'b1; col_kind = KIND_GREY;
                        col_value = {16'd0, grey_mul + dec};
                    end
                    SUB_TRUE_0: red_next = {hex, 4'd0};
                    SUB_TRUE_1: red_next = red_reg | {4'd0, hex};
                    SUB_TRUE_2: green_next = {hex, 4'd0};
                    SUB_TRUE_3: green_next = green_reg | {4'd0, hex};
                    SUB_TRUE_4: blue_next = {hex, 4'd0};
                    default: begin
                        blue_next = blue_reg | {4'd0, hex};
                        col_set = 1'b1; col_kind = KIND_TRUE;
                        col_value = {red_reg, green_reg, blue_next};
                    end
                endcase
                if (col_set) begin
                    phase_next = PH_IDLE;
                    if (which_reg) begin
                        attr_next.bg_kind  = col_kind;
                        attr_next.bg_value = col_value;
                    end else begin
                        attr_next.fg_kind  = col_kind;
                        attr_next.fg_value = col_value;
                    end
                end
            end
            PH_U0: begin
                point_next = {12'd0, hex};
                phase_next = PH_U1;
            end
            PH_U1: begin
                point_next = point_shift;
                phase_next = PH_U2;
            end
            PH_U2: begin
                point_next = point_shift;
                phase_next = PH_U3;
            end
            PH_U3: begin
                point_next = point_shift;
                cell_next.glyph_bytes   = utf8_encode(point_shift);
                cell_next.glyph_is_utf8 = 1'b1;
                done = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase
        cell_next.attr = attr_next;
        emit = done || s_tlast;
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            attr_reg       <= ATTR_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= emit ? PH_IDLE : phase_next;
                attr_reg  <= attr_next;
                which_reg <= which_next;
                sub_reg   <= sub_next;
                code_reg  <= code_next;
                red_reg   <= red_next;
                green_reg <= green_next;
                blue_reg  <= blue_next;
                grey_reg  <= grey_next;
                point_reg <= point_next;
            end
            if (skid_valid_reg) begin
                if (pop) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (accept && emit) begin
                if (!out_valid_reg || pop) begin
                    out_reg       <= cell_next;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= cell_next;
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.glyph_is_utf8;
    assign m_tdata  = {5'd0,
                       out_reg.attr.bg_value, out_reg.attr.bg_kind,
                       out_reg.attr.fg_value, out_reg.attr.fg_kind,
                       out_reg.attr.underline, out_reg.attr.polarity,
                       out_reg.attr.intensity, out_reg.attr.cs_ext,
                       out_reg.attr.cs_code, out_reg.glyph_bytes};

endmodule

FILE: rtl/telp_checker.sv
// ----------------------------------------------------------------------------
// telp_checker
// Port-level checks for the cell literal parser, bound to the top level.
// ----------------------------------------------------------------------------
module telp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [telp_pkg::TDATA_W-1:0] m_tdata,
    input logic                         m_tuser
);
    import telp_pkg::*;

    // output queue empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("cell pending after reset");

    // backpressure only when a cell is already waiting
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // stalled cell holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled cell changed");

    // attribute codes stay in range
    a_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:33] != 2'd3 && m_tdata[39:37] <= KIND_TRUE
                     && m_tdata[66:64] <= KIND_TRUE)
        else $error("attribute code out of range");

    // plain glyphs are a single byte
    a_plain_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[23:8] == 16'd0)
        else $error("plain glyph wider than a byte");

endmodule

bind terminal_element_literal_parser_top telp_checker u_telp_checker (.*);

FILE: sim/terminal_element_literal_parser_top_tb.sv
// ----------------------------------------------------------------------------
// terminal_element_literal_parser_top_tb
// Streams cell literal characters into the parser and checks every cell that
// comes out against a cycle-free model of the parse, kept in this bench.
// Directed characters come first: extreme bytes, attribute reset, an unknown
// escape, code point zero, the charset extender and an early end. Then come
// random literals: mostly well-formed escape runs with random content, some
// raw noise and truncated literals. The sender works in bursts with gaps, the
// receiver stalls on its own changing pattern, and once the sender holds off
// until every predicted cell has arrived.
// ----------------------------------------------------------------------------
module terminal_element_literal_parser_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import telp_pkg::*;

    localparam int RANDOM_CHARS   = 1950;
    localparam int DRAIN_AT       = 700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 10;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ESC, ST_CODE0, ST_CODE1, ST_CODE2, ST_CSET, ST_CSET_EXT,
        ST_INTEN, ST_POL, ST_UL, ST_COLOUR, ST_POINT0, ST_POINT1, ST_POINT2,
        ST_POINT3
    } parse_state_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'd0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;

    terminal_element_literal_parser_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // parser model state
    parse_state_t pstate;
    logic         colour_bg;
    logic [3:0]   colour_sub;
    logic [7:0]   code_sum, red_a, green_a, blue_a, grey_a;
    logic [15:0]  point_a;
    attr_t        attrs;
    logic [23:0]  glyph;
    logic         glyph_utf8;

    char_req_t    pending_chars[$];
    cell_t        cells_due[$];
    logic [7:0]   literal[$];

    bit           tb_running = 1'b0;
    bit           drain_wait = 1'b0;
    int           chars_sent = 0;
    int           chars_taken = 0;
    int           gap_left = 0;
    int           burst_left = 0;
    int           rx_tick = 0;
    int           rx_mode = 0;
    int           idle_cycles = 0;
    int           mismatches = 0;
    char_req_t    next_req;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c[3:0];
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            return 4'(c[3:0] + 4'd9);
        return 4'd0;
    endfunction

    function automatic logic [23:0] encode_point(input logic [15:0] p);
        if (p < 16'h0080)
            return {16'd0, p[7:0]};
        if (p < 16'h0800)
            return {8'd0, 2'b10, p[5:0], 3'b110, p[10:6]};
        return {2'b10, p[5:0], 2'b10, p[11:6], 4'b1110, p[15:12]};
    endfunction

    task automatic clear_attrs();
        attrs.intensity = INTEN_NORMAL;
        attrs.polarity  = 1'b0;
        attrs.underline = 1'b0;
        attrs.fg_kind   = KIND_DEFAULT;
        attrs.fg_value  = 24'd0;
        attrs.bg_kind   = KIND_DEFAULT;
        attrs.bg_value  = 24'd0;
    endtask

    task automatic start_colour(input logic bg, input logic [3:0] sub);
        pstate     = ST_COLOUR;
        colour_bg  = bg;
        colour_sub = sub;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic is_last);
        logic        done;
        logic        fin;
        logic [7:0]  d;
        logic [3:0]  h;
        logic [2:0]  k;
        logic [23:0] v;
        cell_t       due_entry;
        done = 1'b0;
        fin  = 1'b0;
        d    = 8'(c - CH_ZERO);
        h    = hex_nibble(c);
        k    = KIND_DEFAULT;
        v    = 24'd0;
        case (pstate)
            ST_IDLE: begin
                if (c == CH_BACKSLASH) begin
                    pstate = ST_ESC;
                end else begin
                    glyph = {16'd0, c};
                    glyph_utf8 = 1'b0;
                    done = 1'b1;
                end
            end
            ST_ESC: begin
                pstate = ST_IDLE;
                case (c)
                    ESC_CHARCODE: pstate = ST_CODE0;
                    ESC_CHARSET:  pstate = ST_CSET;
                    ESC_INTEN:    pstate = ST_INTEN;
                    ESC_POL:      pstate = ST_POL;
                    ESC_UL:       pstate = ST_UL;
                    ESC_FG_LOW:   start_colour(1'b0, SUB_LOW);
                    ESC_FG_HIGH:  start_colour(1'b0, SUB_HIGH_R);
                    ESC_FG_GREY:  start_colour(1'b0, SUB_GREY_0);
                    ESC_FG_TRUE:  start_colour(1'b0, SUB_TRUE_0);
                    ESC_BG_LOW:   start_colour(1'b1, SUB_LOW);
                    ESC_BG_HIGH:  start_colour(1'b1, SUB_HIGH_R);
                    ESC_BG_GREY:  start_colour(1'b1, SUB_GREY_0);
                    ESC_BG_TRUE:  start_colour(1'b1, SUB_TRUE_0);
                    ESC_UNICODE:  pstate = ST_POINT0;
                    ESC_RESET:    clear_attrs();
                    default: begin
                        glyph = {16'd0, c};
                        glyph_utf8 = 1'b0;
                        done = 1'b1;
                    end
                endcase
            end
            ST_CODE0: begin
                code_sum = d;
                pstate = ST_CODE1;
            end
            ST_CODE1: begin
                code_sum = 8'(code_sum * 8'd10 + d);
                pstate = ST_CODE2;
            end
            ST_CODE2: begin
                code_sum = 8'(code_sum * 8'd10 + d);
                glyph = {16'd0, code_sum};
                glyph_utf8 = 1'b0;
                done = 1'b1;
            end
            ST_CSET: begin
                if (c == CH_PERCENT) begin
                    pstate = ST_CSET_EXT;
                end else begin
                    attrs.cs_code = c;
                    attrs.cs_ext = 1'b0;
                    pstate = ST_IDLE;
                end
            end
            ST_CSET_EXT: begin
                attrs.cs_code = c;
                attrs.cs_ext = 1'b1;
                pstate = ST_IDLE;
            end
            ST_INTEN: begin
                attrs.intensity = (c == CH_GT) ? INTEN_BOLD :
                                  (c == CH_LT) ? INTEN_FAINT : INTEN_NORMAL;
                pstate = ST_IDLE;
            end
            ST_POL: begin
                attrs.polarity = (c == CH_MINUS);
                pstate = ST_IDLE;
            end
            ST_UL: begin
                attrs.underline = (c == CH_PLUS);
                pstate = ST_IDLE;
            end
            ST_COLOUR: begin
                case (colour_sub)
                    SUB_LOW: begin
                        fin = 1'b1; k = KIND_LOW; v = {16'd0, d};
                    end
                    SUB_HIGH_R: red_a = d;
                    SUB_HIGH_G: green_a = d;
                    SUB_HIGH_B: begin
                        fin = 1'b1; k = KIND_HIGH; v = {red_a, green_a, d};
                    end
                    SUB_GREY_0: grey_a = d;
                    SUB_GREY_1: begin
                        fin = 1'b1; k = KIND_GREY; v = {16'd0, 8'(grey_a * 8'd10 + d)};
                    end
                    SUB_TRUE_0: red_a = {h, 4'd0};
                    SUB_TRUE_1: red_a[3:0] = h;
                    SUB_TRUE_2: green_a = {h, 4'd0};
                    SUB_TRUE_3: green_a[3:0] = h;
                    SUB_TRUE_4: blue_a = {h, 4'd0};
                    default: begin
                        blue_a[3:0] = h;
                        fin = 1'b1; k = KIND_TRUE; v = {red_a, green_a, blue_a};
                    end
                endcase
                if (fin) begin
                    pstate = ST_IDLE;
                    if (colour_bg) begin
                        attrs.bg_kind = k;
                        attrs.bg_value = v;
                    end else begin
                        attrs.fg_kind = k;
                        attrs.fg_value = v;
                    end
                end else begin
                    colour_sub = 4'(colour_sub + 4'd1);
                end
            end
            ST_POINT0: begin
                point_a = {12'd0, h};
                pstate = ST_POINT1;
            end
            ST_POINT1, ST_POINT2: begin
                point_a = {point_a[11:0], h};
                pstate = (pstate == ST_POINT1) ? ST_POINT2 : ST_POINT3;
            end
            default: begin
                point_a = {point_a[11:0], h};
                glyph = encode_point(point_a);
                glyph_utf8 = 1'b1;
                done = 1'b1;
            end
        endcase
        if (done || is_last) begin
            due_entry.glyph_bytes   = glyph;
            due_entry.glyph_is_utf8 = glyph_utf8;
            due_entry.attr          = attrs;
            cells_due.push_back(due_entry);
            pstate     = ST_IDLE;
            code_sum   = 8'd0;
            red_a      = 8'd0;
            green_a    = 8'd0;
            blue_a     = 8'd0;
            grey_a     = 8'd0;
            point_a    = 16'd0;
            glyph      = GLYPH_SPACE;
            glyph_utf8 = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_cell();
        cell_t want;
        if (cells_due.size() == 0) begin
            $error("cell 0x%0h arrived with no request pending", m_tdata);
            mismatches++;
        end else begin
            want = cells_due.pop_front();
            check_field("glyph_bytes", want.glyph_bytes, m_tdata[23:0]);
            check_field("glyph_is_utf8", 24'(want.glyph_is_utf8), 24'(m_tuser));
            check_field("charset_designator", 24'(want.attr.cs_code),
                        24'(m_tdata[31:24]));
            check_field("charset_extended", 24'(want.attr.cs_ext), 24'(m_tdata[32]));
            check_field("intensity_out", 24'(want.attr.intensity), 24'(m_tdata[34:33]));
            check_field("polarity_out", 24'(want.attr.polarity), 24'(m_tdata[35]));
            check_field("underline_out", 24'(want.attr.underline), 24'(m_tdata[36]));
            check_field("fg_kind", 24'(want.attr.fg_kind), 24'(m_tdata[39:37]));
            check_field("fg_value", want.attr.fg_value, m_tdata[63:40]);
            check_field("bg_kind", 24'(want.attr.bg_kind), 24'(m_tdata[66:64]));
            check_field("bg_value", want.attr.bg_value, m_tdata[90:67]);
        end
    endtask

    task automatic queue_char(input logic [7:0] c, input logic is_last);
        char_req_t r;
        r.ch = c;
        r.last = is_last;
        pending_chars.push_back(r);
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] dec_char();
        if ($urandom_range(0, 7) == 0)
            return rand_byte();
        return 8'(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if ($urandom_range(0, 7) == 0)
            return rand_byte();
        if (n < 4'd10)
            return 8'(CH_ZERO + 8'(n));
        return 8'((($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10);
    endfunction

    task automatic add_attribute_escape();
        logic       bg;
        logic [7:0] code;
        int         form;
        bg = 1'($urandom_range(0, 1));
        literal.push_back(CH_BACKSLASH);
        case ($urandom_range(0, 6))
            0: begin
                literal.push_back(ESC_CHARSET);
                if ($urandom_range(0, 2) == 0)
                    literal.push_back(CH_PERCENT);
                literal.push_back(rand_byte());
            end
            1: begin
                literal.push_back(ESC_INTEN);
                case ($urandom_range(0, 2))
                    0: literal.push_back(CH_GT);
                    1: literal.push_back(CH_LT);
                    default: literal.push_back(rand_byte());
                endcase
            end
            2: begin
                literal.push_back(ESC_POL);
                literal.push_back(($urandom_range(0, 1) == 0) ? CH_MINUS : rand_byte());
            end
            3: begin
                literal.push_back(ESC_UL);
                literal.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : rand_byte());
            end
            4, 5: begin
                form = $urandom_range(0, 3);
                case (form)
                    0: code = bg ? ESC_BG_LOW : ESC_FG_LOW;
                    1: code = bg ? ESC_BG_HIGH : ESC_FG_HIGH;
                    2: code = bg ? ESC_BG_GREY : ESC_FG_GREY;
                    default: code = bg ? ESC_BG_TRUE : ESC_FG_TRUE;
                endcase
                literal.push_back(code);
                case (form)
                    0: literal.push_back(dec_char());
                    1: repeat (3) literal.push_back(dec_char());
                    2: repeat (2) literal.push_back(dec_char());
                    default: repeat (6) literal.push_back(hex_char(4'($urandom_range(0, 15))));
                endcase
            end
            default: literal.push_back(ESC_RESET);
        endcase
    endtask

    task automatic add_code_point();
        logic [15:0] p;
        case ($urandom_range(0, 3))
            0: p = 16'($urandom_range(0, 16'h007F));
            1: p = 16'($urandom_range(16'h0080, 16'h07FF));
            2: p = 16'($urandom_range(16'h0800, 16'hFFFF));
            default: begin
                case ($urandom_range(0, 5))
                    0: p = 16'h0000;
                    1: p = 16'h007F;
                    2: p = 16'h0080;
                    3: p = 16'h07FF;
                    4: p = 16'h0800;
                    default: p = 16'hFFFF;
                endcase
            end
        endcase
        literal.push_back(CH_BACKSLASH);
        literal.push_back(ESC_UNICODE);
        literal.push_back(hex_char(p[15:12]));
        literal.push_back(hex_char(p[11:8]));
        literal.push_back(hex_char(p[7:4]));
        literal.push_back(hex_char(p[3:0]));
    endtask

    task automatic make_random_literal();
        logic [7:0] c;
        bit         noise;
        int         mark;
        literal.delete();
        noise = ($urandom_range(0, 9) == 0);
        if (noise) begin
            repeat ($urandom_range(1, 6)) literal.push_back(rand_byte());
        end else begin
            repeat ($urandom_range(0, 3)) add_attribute_escape();
            case ($urandom_range(0, 5))
                0, 1: begin
                    c = rand_byte();
                    literal.push_back((c == CH_BACKSLASH) ? CH_ZERO : c);
                end
                2: begin
                    literal.push_back(CH_BACKSLASH);
                    literal.push_back(ESC_CHARCODE);
                    repeat (3) literal.push_back(dec_char());
                end
                3: add_code_point();
                4: begin
                    literal.push_back(CH_BACKSLASH);
                    literal.push_back(rand_byte());
                end
                default: ;
            endcase
        end
        mark = -1;
        if (literal.size() > 0 && (noise || $urandom_range(0, 5) == 0))
            mark = $urandom_range(0, literal.size() - 1);
        foreach (literal[i]) begin
            if (mark < 0 || i <= mark)
                queue_char(literal[i], (i == mark) ||
                           (noise && $urandom_range(0, 3) == 0));
        end
    endtask

    // sender and receiver
    always @(negedge aclk) begin
        if (tb_running) begin
            if (s_tvalid && chars_taken != chars_sent) begin
                // request still waiting for s_tready
            end else if (drain_wait) begin
                s_tvalid <= 1'b0;
                if (chars_taken == chars_sent && cells_due.size() == 0)
                    drain_wait = 1'b0;
            end else if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (pending_chars.size() > 0) begin
                next_req = pending_chars.pop_front();
                s_tdata  <= next_req.ch;
                s_tlast  <= next_req.last;
                s_tvalid <= 1'b1;
                chars_sent++;
                if (chars_sent == DRAIN_AT)
                    drain_wait = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end

            rx_tick++;
            if (rx_tick % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_tick % 4 == 0);
                default: m_tready <= (rx_tick % 16 >= 12);
            endcase
        end
    end

    // handshake monitor, model update and watchdog
    always @(posedge aclk) begin
        if (tb_running) begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (m_tvalid && m_tready)
                compare_cell();
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata, s_tlast);
                chars_taken++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("terminal_element_literal_parser_top_tb failed");
                $finish;
            end
        end
    end

    initial begin
        clear_attrs();
        attrs.cs_code = CHARSET_RESET;
        attrs.cs_ext  = 1'b0;
        pstate     = ST_IDLE;
        colour_bg  = 1'b0;
        colour_sub = SUB_LOW;
        code_sum   = 8'd0;
        red_a      = 8'd0;
        green_a    = 8'd0;
        blue_a     = 8'd0;
        grey_a     = 8'd0;
        point_a    = 16'd0;
        glyph      = GLYPH_SPACE;
        glyph_utf8 = 1'b0;

        // extreme bytes as plain glyphs
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        // attribute reset, then an unknown escape code as glyph
        queue_char(CH_BACKSLASH, 1'b0);
        queue_char(ESC_RESET, 1'b0);
        queue_char(CH_BACKSLASH, 1'b0);
        queue_char("q", 1'b0);
        // code point zero
        queue_char(CH_BACKSLASH, 1'b0);
        queue_char(ESC_UNICODE, 1'b0);
        repeat (4) queue_char(CH_ZERO, 1'b0);
        // extended charset designator, faint, then early end inside an escape
        queue_char(CH_BACKSLASH, 1'b0);
        queue_char(ESC_CHARSET, 1'b0);
        queue_char(CH_PERCENT, 1'b0);
        queue_char("A", 1'b0);
        queue_char(CH_BACKSLASH, 1'b0);
        queue_char(ESC_INTEN, 1'b0);
        queue_char(CH_LT, 1'b0);
        queue_char(CH_BACKSLASH, 1'b0);
        queue_char(ESC_POL, 1'b1);

        while (pending_chars.size() < RANDOM_CHARS + 21)
            make_random_literal();

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        tb_running = 1'b1;

        while (pending_chars.size() > 0 || chars_taken != chars_sent)
            @(posedge aclk);
        while (cells_due.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("terminal_element_literal_parser_top_tb passed");
        else
            $display("terminal_element_literal_parser_top_tb failed");
        $finish;
    end

endmodule
